// ----- rtl/core/ftbm_pkg.sv -----
package ftbm_pkg;

	// field widths
	localparam int FRAME_W   = 24;
	localparam int PHASE_W   = 20;
	localparam int COUNT_W   = 32;
	localparam int FPS_W     = 20;
	localparam int CLASS_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = FRAME_W;

	// running sum is wide enough for a saturated count of full-scale frames
	localparam int SUM_W = FRAME_W + COUNT_W;

	// shared divider sizing: quotient bits per pass and divisor width
	localparam int QUO_W  = (FRAME_W > FPS_W) ? FRAME_W : FPS_W;
	localparam int DIVR_W = (COUNT_W > FRAME_W) ? COUNT_W : FRAME_W;
	localparam int STEP_W = $clog2(QUO_W + 1);

	localparam logic [FPS_W-1:0] FPS_NUMERATOR = FPS_W'(1000000);

	// register reset values
	localparam logic [FRAME_W-1:0] RST_FRAME_BUDGET = FRAME_W'(16667);
	localparam logic [FRAME_W-1:0] RST_SOFT         = FRAME_W'(20000);
	localparam logic [FRAME_W-1:0] RST_CLASS_C      = FRAME_W'(25000);
	localparam logic [FRAME_W-1:0] RST_HARD         = FRAME_W'(33334);
	localparam logic [PHASE_W-1:0] RST_SHORT_PHASE  = PHASE_W'(500);
	localparam logic [PHASE_W-1:0] RST_MID_PHASE    = PHASE_W'(2000);
	localparam logic [PHASE_W-1:0] RST_TEXT_PHASE   = PHASE_W'(1500);
	localparam logic [PHASE_W-1:0] RST_RENDER_PHASE = PHASE_W'(6000);

	// command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// frame classes
	localparam logic [CLASS_W-1:0] CLASS_A = 3'd0;
	localparam logic [CLASS_W-1:0] CLASS_B = 3'd1;
	localparam logic [CLASS_W-1:0] CLASS_C = 3'd2;
	localparam logic [CLASS_W-1:0] CLASS_D = 3'd3;
	localparam logic [CLASS_W-1:0] CLASS_E = 3'd4;

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_BUDGET = 3'd0,
		REG_SOFT         = 3'd1,
		REG_CLASS_C      = 3'd2,
		REG_HARD         = 3'd3,
		REG_SHORT_PHASE  = 3'd4,
		REG_MID_PHASE    = 3'd5,
		REG_TEXT_PHASE   = 3'd6,
		REG_RENDER_PHASE = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_FPS_START,
		ST_FPS_WAIT,
		ST_AVG_START,
		ST_AVG_WAIT,
		ST_WRITE
	} ftbm_state_t;

	typedef struct packed {
		logic               cmd;
		logic [FRAME_W-1:0] frame_time;
		logic [PHASE_W-1:0] input_time;
		logic [PHASE_W-1:0] event_time;
		logic [PHASE_W-1:0] layout_time;
		logic [PHASE_W-1:0] animation_time;
		logic [PHASE_W-1:0] text_time;
		logic [PHASE_W-1:0] render_time;
		logic [PHASE_W-1:0] compositor_time;
		logic [PHASE_W-1:0] presentation_time;
	} sample_t;

	typedef struct packed {
		logic               on_budget;
		logic [CLASS_W-1:0] grade;
		logic [FPS_W-1:0]   frames_per_second;
		logic [FRAME_W-1:0] minimum_frame;
		logic [FRAME_W-1:0] maximum_frame;
		logic [FRAME_W-1:0] average_frame;
		logic [COUNT_W-1:0] frame_total;
		logic [COUNT_W-1:0] budget_violations;
		logic [COUNT_W-1:0] soft_overruns;
		logic [COUNT_W-1:0] hard_overruns;
		logic [COUNT_W-1:0] phase_overruns;
		logic               throttled;
	} result_t;

	// divider start request
	typedef struct packed {
		logic              start;
		logic [QUO_W-1:0]  dividend;
		logic [DIVR_W-1:0] rem_init;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// saturating counter increment
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (&v) ? v : v + COUNT_W'(1);
	endfunction

endpackage

// ----- rtl/core/ftbm_div.sv -----
module ftbm_div
	import ftbm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output div_stat_t        stat,
	output logic [QUO_W-1:0] quotient
);

	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [QUO_W-1:0]  dvd_q;
	logic [STEP_W-1:0] steps_q;
	logic              busy_q;
	logic              done_q;

	logic [DIVR_W:0] trial;
	logic [DIVR_W:0] diff;
	logic            take;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, dvd_q[QUO_W-1]};
		diff  = trial - {1'b0, dvs_q};
		take  = ~diff[DIVR_W];
	end

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				steps_q <= STEP_W'(QUO_W);
			end else if (busy_q) begin
				steps_q <= steps_q - STEP_W'(1);
				if (steps_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder, divisor and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			dvs_q <= req.divisor;
			dvd_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], take};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

// ----- rtl/core/frame_time_budget_monitor.sv -----
// A frame word passes through update, the fps division, the average division and the write;
// a clear word skips both divisions. A frame with zero frame time, or whose average would
// overflow, skips that division; the write waits until the output register is free.
// One word at a time: sample_ready is high only while idle. Both divisions use the shared
// restoring divider, one quotient bit per cycle, run once for fps and once for the average.
// Reset (arst_n low, asynchronous): statistics zero, limits to defaults, no result pending.
module frame_time_budget_monitor
	import ftbm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// limits
	logic [FRAME_W-1:0] budget_lim_q, soft_lim_q, class_c_lim_q, hard_lim_q;
	logic [PHASE_W-1:0] short_lim_q, mid_lim_q, text_lim_q, render_lim_q;

	// statistics
	logic [FRAME_W-1:0] min_q, max_q;
	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q, budget_cnt_q, soft_cnt_q, hard_cnt_q, phase_cnt_q;
	logic               limited_q;

	// per-word working registers
	ftbm_state_t        state_q, state_d;
	sample_t            smp_q;
	logic               within_q;
	logic [CLASS_W-1:0] cls_q;
	logic [FPS_W-1:0]   fps_q;
	logic [FRAME_W-1:0] avg_q;
	result_t            out_q;
	logic               out_valid_q;

	div_req_t           div_req;
	div_stat_t          div_stat;
	logic [QUO_W-1:0]   div_quo;
	logic               out_load;

	logic [FRAME_W-1:0] ft;
	logic               phase_over, frame_over;
	logic [SUM_W:0]     sum_ext;
	logic [SUM_W-1:0]   sum_next;
	logic [CLASS_W-1:0] cls_next;
	logic [DIVR_W-1:0]  sum_hi, count_ext;
	logic               avg_ovf;
	logic [FRAME_W-1:0] avg_capped;

	ftbm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// frame checks and sum update
	always_comb begin
		ft = smp_q.frame_time;
		phase_over = (smp_q.input_time > short_lim_q) || (smp_q.event_time > short_lim_q) ||
			(smp_q.layout_time > mid_lim_q) || (smp_q.animation_time > mid_lim_q) ||
			(smp_q.text_time > text_lim_q) || (smp_q.render_time > render_lim_q) ||
			(smp_q.compositor_time > mid_lim_q) || (smp_q.presentation_time > text_lim_q);
		frame_over = ft > budget_lim_q;
		sum_ext    = {1'b0, sum_q} + (SUM_W + 1)'(ft);
		sum_next   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		if (ft <= budget_lim_q)
			cls_next = CLASS_A;
		else if (ft <= soft_lim_q)
			cls_next = CLASS_B;
		else if (ft <= class_c_lim_q)
			cls_next = CLASS_C;
		else if (ft <= hard_lim_q)
			cls_next = CLASS_D;
		else
			cls_next = CLASS_E;
	end

	// average: upper sum bits seed the remainder; quotient too wide means cap at max
	always_comb begin
		sum_hi     = DIVR_W'(sum_q[SUM_W-1:QUO_W]);
		count_ext  = DIVR_W'(count_q);
		avg_ovf    = sum_hi >= count_ext;
		avg_capped = (div_quo > QUO_W'(max_q)) ? max_q : div_quo[FRAME_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (sample_valid) state_d = ST_UPDATE;
			ST_UPDATE:
				state_d = (smp_q.cmd == CMD_CLEAR) ? ST_AVG_START : ST_FPS_START;
			ST_FPS_START:
				state_d = (ft == '0) ? ST_AVG_START : ST_FPS_WAIT;
			ST_FPS_WAIT:
				if (div_stat.done) state_d = ST_AVG_START;
			ST_AVG_START:
				state_d = (count_q == '0 || avg_ovf) ? ST_WRITE : ST_AVG_WAIT;
			ST_AVG_WAIT:
				if (div_stat.done) state_d = ST_WRITE;
			ST_WRITE:
				if (!out_valid_q || result_ready) state_d = ST_IDLE;
			default:
				state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample_ready = 1'b0;
		out_load     = 1'b0;
		div_req      = '0;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
			end
			ST_FPS_START: begin
				div_req.start    = (ft != '0);
				div_req.dividend = QUO_W'(FPS_NUMERATOR);
				div_req.rem_init = '0;
				div_req.divisor  = DIVR_W'(ft);
			end
			ST_AVG_START: begin
				div_req.start    = (count_q != '0) && !avg_ovf;
				div_req.dividend = sum_q[QUO_W-1:0];
				div_req.rem_init = sum_hi;
				div_req.divisor  = count_ext;
			end
			ST_WRITE: begin
				out_load = !out_valid_q || result_ready;
			end
			default: begin
				sample_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_lim_q  <= RST_FRAME_BUDGET;
			soft_lim_q    <= RST_SOFT;
			class_c_lim_q <= RST_CLASS_C;
			hard_lim_q    <= RST_HARD;
			short_lim_q   <= RST_SHORT_PHASE;
			mid_lim_q     <= RST_MID_PHASE;
			text_lim_q    <= RST_TEXT_PHASE;
			render_lim_q  <= RST_RENDER_PHASE;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_BUDGET: budget_lim_q  <= cfg_data[FRAME_W-1:0];
				REG_SOFT:         soft_lim_q    <= cfg_data[FRAME_W-1:0];
				REG_CLASS_C:      class_c_lim_q <= cfg_data[FRAME_W-1:0];
				REG_HARD:         hard_lim_q    <= cfg_data[FRAME_W-1:0];
				REG_SHORT_PHASE:  short_lim_q   <= cfg_data[PHASE_W-1:0];
				REG_MID_PHASE:    mid_lim_q     <= cfg_data[PHASE_W-1:0];
				REG_TEXT_PHASE:   text_lim_q    <= cfg_data[PHASE_W-1:0];
				REG_RENDER_PHASE: render_lim_q  <= cfg_data[PHASE_W-1:0];
				default:          budget_lim_q  <= budget_lim_q;
			endcase
		end
	end

	// statistics update, once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q        <= '0;
			max_q        <= '0;
			sum_q        <= '0;
			count_q      <= '0;
			budget_cnt_q <= '0;
			soft_cnt_q   <= '0;
			hard_cnt_q   <= '0;
			phase_cnt_q  <= '0;
			limited_q    <= 1'b0;
		end else if (state_q == ST_UPDATE) begin
			if (smp_q.cmd == CMD_CLEAR) begin
				min_q        <= '0;
				max_q        <= '0;
				sum_q        <= '0;
				count_q      <= '0;
				budget_cnt_q <= '0;
				soft_cnt_q   <= '0;
				hard_cnt_q   <= '0;
				phase_cnt_q  <= '0;
				limited_q    <= 1'b0;
			end else begin
				if (frame_over || phase_over) begin
					budget_cnt_q <= sat_inc(budget_cnt_q);
					limited_q    <= 1'b1;
				end
				if (phase_over) phase_cnt_q <= sat_inc(phase_cnt_q);
				if (ft > soft_lim_q) soft_cnt_q <= sat_inc(soft_cnt_q);
				if (ft > hard_lim_q) hard_cnt_q <= sat_inc(hard_cnt_q);
				count_q <= sat_inc(count_q);
				if (min_q == '0 || ft < min_q) min_q <= ft;
				if (ft > max_q) max_q <= ft;
				sum_q <= sum_next;
			end
		end
	end

	// working registers for the word in flight
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) smp_q <= sample;
		case (state_q)
			ST_UPDATE: begin
				within_q <= (smp_q.cmd == CMD_CLEAR) || !(frame_over || phase_over);
				cls_q    <= (smp_q.cmd == CMD_CLEAR) ? CLASS_A : cls_next;
				fps_q    <= '0;
			end
			ST_FPS_WAIT: begin
				if (div_stat.done) fps_q <= div_quo[FPS_W-1:0];
			end
			ST_AVG_START: begin
				avg_q <= (count_q != '0 && avg_ovf) ? max_q : '0;
			end
			ST_AVG_WAIT: begin
				if (div_stat.done) avg_q <= avg_capped;
			end
			default: begin
				avg_q <= avg_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (result_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.on_budget         <= within_q;
			out_q.grade             <= cls_q;
			out_q.frames_per_second <= fps_q;
			out_q.minimum_frame     <= min_q;
			out_q.maximum_frame     <= max_q;
			out_q.average_frame     <= avg_q;
			out_q.frame_total       <= count_q;
			out_q.budget_violations <= budget_cnt_q;
			out_q.soft_overruns     <= soft_cnt_q;
			out_q.hard_overruns     <= hard_cnt_q;
			out_q.phase_overruns    <= phase_cnt_q;
			out_q.throttled         <= limited_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	// tracked minimum never passes the maximum
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		min_q <= max_q)
		else $error("minimum frame above maximum frame");

	// every phase violation is also a budget violation
	a_phase_le_budget: assert property (@(posedge clk) disable iff (!arst_n)
		phase_cnt_q <= budget_cnt_q)
		else $error("phase count above budget count");

	// divider runs and finishes only while the sequencer waits for it
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		(div_stat.busy || div_stat.done) |->
			(state_q == ST_FPS_WAIT || state_q == ST_AVG_WAIT))
		else $error("divider active with no waiting state");

	// reported average is capped at the maximum
	a_avg_capped: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_q.average_frame <= out_q.maximum_frame))
		else $error("average frame above maximum frame");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import ftbm_pkg::*;

	localparam int WATCHDOG     = 2000;  // cycles with no handshake at all
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int END_SLACK    = 60;    // a little more than the frame latency
	localparam int PHASE_WORDS  = 130;   // random words per limit setting
	localparam int N_SETTINGS   = 6;
	localparam int MAX_REPORTS  = 10;

	localparam logic [SUM_W-1:0] SUM_TOP = '1;

	// limit settings walked by the random part
	typedef enum int {
		LIM_ORDERED,
		LIM_ZERO,
		LIM_SCATTER,
		LIM_FULL,
		LIM_DEFAULT
	} lim_plan_t;

	// directed row: word, and an optional hand-written expectation
	typedef struct packed {
		sample_t word;
		logic    typed;
		result_t want;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_ready;
	sample_t              sample = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// mirror of the block: limits and running statistics
	logic [CFG_W-1:0]   lim [8];
	logic [FRAME_W-1:0] min_ft;
	logic [FRAME_W-1:0] max_ft;
	logic [SUM_W-1:0]   ft_sum;
	logic [COUNT_W-1:0] n_frames;
	logic [COUNT_W-1:0] n_budget;
	logic [COUNT_W-1:0] n_soft;
	logic [COUNT_W-1:0] n_hard;
	logic [COUNT_W-1:0] n_phase;
	logic               limited;

	result_t stats_q [$];
	row_t    rows [$];

	int  n_err = 0;
	int  n_results = 0;
	int  n_sent = 0;
	int  n_clears = 0;
	int  n_over = 0;
	int  quiet = 0;
	bit  send_burst = 0;
	bit  recv_burst = 0;

	frame_time_budget_monitor DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// statistics mirror
	// ------------------------------------------------------------------
	function automatic void clear_stats();
		min_ft   = '0;
		max_ft   = '0;
		ft_sum   = '0;
		n_frames = '0;
		n_budget = '0;
		n_soft   = '0;
		n_hard   = '0;
		n_phase  = '0;
		limited  = 1'b0;
	endfunction

	function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
		return (&v) ? v : v + COUNT_W'(1);
	endfunction

	function automatic logic [PHASE_W-1:0] phase_of(sample_t s, int i);
		case (i)
			0: return s.input_time;
			1: return s.event_time;
			2: return s.layout_time;
			3: return s.animation_time;
			4: return s.text_time;
			5: return s.render_time;
			6: return s.compositor_time;
			default: return s.presentation_time;
		endcase
	endfunction

	// limit that applies to phase i
	function automatic logic [PHASE_W-1:0] phase_cap(int i);
		case (i)
			0, 1: return lim[REG_SHORT_PHASE][PHASE_W-1:0];
			2, 3, 6: return lim[REG_MID_PHASE][PHASE_W-1:0];
			4, 7: return lim[REG_TEXT_PHASE][PHASE_W-1:0];
			default: return lim[REG_RENDER_PHASE][PHASE_W-1:0];
		endcase
	endfunction

	// apply one word to the mirror and return the result it should produce
	function automatic result_t predict_stats(sample_t s);
		result_t            r;
		logic               phase_over;
		logic               frame_over;
		logic [FRAME_W-1:0] ft;
		logic [SUM_W-1:0]   q;
		r = '0;
		r.on_budget = 1'b1;
		r.grade = CLASS_A;
		if (s.cmd == CMD_CLEAR) begin
			clear_stats();
		end else begin
			ft = s.frame_time;
			phase_over = 1'b0;
			for (int i = 0; i < 8; i++) begin
				if (phase_of(s, i) > phase_cap(i))
					phase_over = 1'b1;
			end
			frame_over = ft > lim[REG_FRAME_BUDGET];
			if (frame_over || phase_over) begin
				n_budget = bump(n_budget);
				limited = 1'b1;
				r.on_budget = 1'b0;
			end
			if (phase_over)
				n_phase = bump(n_phase);
			if (ft > lim[REG_SOFT])
				n_soft = bump(n_soft);
			if (ft > lim[REG_HARD])
				n_hard = bump(n_hard);
			n_frames = bump(n_frames);
			r.frames_per_second = (ft != 0) ? FPS_W'(32'd1000000 / ft) : '0;
			// zero minimum means nothing tracked yet
			if (min_ft == 0 || ft < min_ft)
				min_ft = ft;
			if (ft > max_ft)
				max_ft = ft;
			ft_sum = (ft_sum > SUM_TOP - ft) ? SUM_TOP : ft_sum + ft;
			if (ft <= lim[REG_FRAME_BUDGET])
				r.grade = CLASS_A;
			else if (ft <= lim[REG_SOFT])
				r.grade = CLASS_B;
			else if (ft <= lim[REG_CLASS_C])
				r.grade = CLASS_C;
			else if (ft <= lim[REG_HARD])
				r.grade = CLASS_D;
			else
				r.grade = CLASS_E;
		end
		if (n_frames != 0) begin
			q = ft_sum / SUM_W'(n_frames);
			if (q > SUM_W'(max_ft))
				q = SUM_W'(max_ft);
			r.average_frame = q[FRAME_W-1:0];
		end
		r.minimum_frame = min_ft;
		r.maximum_frame = max_ft;
		r.frame_total = n_frames;
		r.budget_violations = n_budget;
		r.soft_overruns = n_soft;
		r.hard_overruns = n_hard;
		r.phase_overruns = n_phase;
		r.throttled = limited;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// word construction
	// ------------------------------------------------------------------
	function automatic sample_t make_word(logic c, logic [FRAME_W-1:0] ft,
			logic [PHASE_W-1:0] p0, logic [PHASE_W-1:0] p1, logic [PHASE_W-1:0] p2,
			logic [PHASE_W-1:0] p3, logic [PHASE_W-1:0] p4, logic [PHASE_W-1:0] p5,
			logic [PHASE_W-1:0] p6, logic [PHASE_W-1:0] p7);
		sample_t s;
		s.cmd = c;
		s.frame_time = ft;
		s.input_time = p0;
		s.event_time = p1;
		s.layout_time = p2;
		s.animation_time = p3;
		s.text_time = p4;
		s.render_time = p5;
		s.compositor_time = p6;
		s.presentation_time = p7;
		return s;
	endfunction

	// statistics right after a clear, with total frames counted since
	function automatic result_t fresh_result(logic [COUNT_W-1:0] total);
		result_t r;
		r = '0;
		r.on_budget = 1'b1;
		r.grade = CLASS_A;
		r.frame_total = total;
		return r;
	endfunction

	// random word: frame times cluster on the class bounds, phases mostly legal
	function automatic sample_t rand_word();
		logic [PHASE_W-1:0] p [8];
		logic [FRAME_W-1:0] ft;
		logic               clean;
		logic               c;
		int                 pick;
		int                 k;
		clean = ($urandom_range(0, 1) == 0);
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			k = $urandom_range(0, 3);
			ft = lim[k] + FRAME_W'($urandom_range(0, 4)) - FRAME_W'(2);
		end else if (pick == 6) begin
			case ($urandom_range(0, 2))
				0: ft = '0;
				1: ft = '1;
				default: ft = FRAME_W'($urandom_range(1, 3));
			endcase
		end else if (pick == 7) begin
			ft = FRAME_W'($urandom);
		end else begin
			ft = FRAME_W'($urandom_range(0, 40000));
		end
		for (int i = 0; i < 8; i++) begin
			pick = $urandom_range(0, 19);
			if (clean || pick < 14)
				p[i] = PHASE_W'($urandom_range(0, phase_cap(i)));
			else if (pick < 17)
				p[i] = phase_cap(i) + PHASE_W'($urandom_range(0, 1));
			else
				p[i] = PHASE_W'($urandom);
		end
		c = ($urandom_range(0, 39) == 0) ? CMD_CLEAR : CMD_SAMPLE;
		return make_word(c, ft, p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic note_error(string msg);
		n_err++;
		if (n_err <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want)
			note_error($sformatf("result %0d, %s: expected %0h, got %0h",
				n_results, name, want, got));
	endtask

	task automatic check_result(result_t got);
		result_t want;
		if (stats_q.size() == 0) begin
			note_error($sformatf("result %0d arrived with nothing expected", n_results));
		end else begin
			want = stats_q.pop_front();
			check_field("on_budget", 32'(want.on_budget), 32'(got.on_budget));
			check_field("grade", 32'(want.grade), 32'(got.grade));
			check_field("frames_per_second", 32'(want.frames_per_second),
				32'(got.frames_per_second));
			check_field("minimum_frame", 32'(want.minimum_frame), 32'(got.minimum_frame));
			check_field("maximum_frame", 32'(want.maximum_frame), 32'(got.maximum_frame));
			check_field("average_frame", 32'(want.average_frame), 32'(got.average_frame));
			check_field("frame_total", want.frame_total, got.frame_total);
			check_field("budget_violations", want.budget_violations,
				got.budget_violations);
			check_field("soft_overruns", want.soft_overruns, got.soft_overruns);
			check_field("hard_overruns", want.hard_overruns, got.hard_overruns);
			check_field("phase_overruns", want.phase_overruns, got.phase_overruns);
			check_field("throttled", 32'(want.throttled), 32'(got.throttled));
			if (!want.on_budget)
				n_over++;
		end
		n_results++;
	endtask

	// ------------------------------------------------------------------
	// drivers; each task starts and ends on a falling edge
	// ------------------------------------------------------------------
	task automatic set_limit(cfg_reg_t idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		lim[idx] = (idx >= REG_SHORT_PHASE) ? CFG_W'(value[PHASE_W-1:0]) : value;
	endtask

	task automatic send_word(sample_t w, logic typed, result_t want);
		int      gap;
		result_t r;
		if ($urandom_range(0, 29) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= w;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		// accepted: update the mirror now, the result comes later
		r = predict_stats(w);
		stats_q.push_back(typed ? want : r);
		n_sent++;
		if (w.cmd == CMD_CLEAR)
			n_clears++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (stats_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic apply_setting(lim_plan_t plan);
		logic [CFG_W-1:0] v [8];
		case (plan)
			LIM_ZERO: begin
				for (int i = 0; i < 8; i++)
					v[i] = '0;
			end
			LIM_FULL: begin
				for (int i = 0; i < 8; i++)
					v[i] = '1;
			end
			LIM_SCATTER: begin
				// unordered bounds, phase writes carry junk above bit 19
				for (int i = 0; i < 8; i++)
					v[i] = CFG_W'($urandom);
			end
			LIM_DEFAULT: begin
				v[REG_FRAME_BUDGET] = RST_FRAME_BUDGET;
				v[REG_SOFT] = RST_SOFT;
				v[REG_CLASS_C] = RST_CLASS_C;
				v[REG_HARD] = RST_HARD;
				v[REG_SHORT_PHASE] = CFG_W'(RST_SHORT_PHASE);
				v[REG_MID_PHASE] = CFG_W'(RST_MID_PHASE);
				v[REG_TEXT_PHASE] = CFG_W'(RST_TEXT_PHASE);
				v[REG_RENDER_PHASE] = CFG_W'(RST_RENDER_PHASE);
			end
			default: begin
				v[REG_FRAME_BUDGET] = CFG_W'($urandom_range(1000, 30000));
				v[REG_SOFT] = v[REG_FRAME_BUDGET] + CFG_W'($urandom_range(0, 8000));
				v[REG_CLASS_C] = v[REG_SOFT] + CFG_W'($urandom_range(0, 8000));
				v[REG_HARD] = v[REG_CLASS_C] + CFG_W'($urandom_range(0, 15000));
				for (int i = 4; i < 8; i++)
					v[i] = CFG_W'($urandom_range(0, 8000));
			end
		endcase
		for (int i = 0; i < 8; i++)
			set_limit(cfg_reg_t'(i), v[i]);
	endtask

	// ------------------------------------------------------------------
	// receiver: random stalls, two long hold-offs to back the block up
	// ------------------------------------------------------------------
	initial begin : drain
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				recv_burst = !recv_burst;
			stall = recv_burst ? 0 : $urandom_range(0, 7);
			if (n_results == 100 || n_results == 500)
				stall = HOLD_CYCLES;
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
			check_result(result);
			@(negedge clk);
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WATCHDOG) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [PHASE_W-1:0] p [8];
		logic [PHASE_W-1:0] z;
		row_t               row;
		result_t            ext;

		lim[REG_FRAME_BUDGET] = RST_FRAME_BUDGET;
		lim[REG_SOFT] = RST_SOFT;
		lim[REG_CLASS_C] = RST_CLASS_C;
		lim[REG_HARD] = RST_HARD;
		lim[REG_SHORT_PHASE] = CFG_W'(RST_SHORT_PHASE);
		lim[REG_MID_PHASE] = CFG_W'(RST_MID_PHASE);
		lim[REG_TEXT_PHASE] = CFG_W'(RST_TEXT_PHASE);
		lim[REG_RENDER_PHASE] = CFG_W'(RST_RENDER_PHASE);
		clear_stats();
		z = '0;

		// directed table, default limits
		row = '0;
		row.word = make_word(CMD_CLEAR, '0, z, z, z, z, z, z, z, z);
		row.typed = 1'b1;
		row.want = fresh_result(0);
		rows.push_back(row);
		row.word = make_word(CMD_SAMPLE, '0, z, z, z, z, z, z, z, z);
		row.want = fresh_result(1);
		rows.push_back(row);
		row.typed = 1'b0;
		row.want = '0;
		row.word = make_word(CMD_SAMPLE, 24'd1, z, z, z, z, z, z, z, z);
		rows.push_back(row);
		// every phase exactly at its limit, frame exactly on budget
		row.word = make_word(CMD_SAMPLE, RST_FRAME_BUDGET,
			RST_SHORT_PHASE, RST_SHORT_PHASE, RST_MID_PHASE, RST_MID_PHASE,
			RST_TEXT_PHASE, RST_RENDER_PHASE, RST_MID_PHASE, RST_TEXT_PHASE);
		rows.push_back(row);
		// class bounds, each on and one above
		row.word = make_word(CMD_SAMPLE, RST_FRAME_BUDGET + FRAME_W'(1),
			z, z, z, z, z, z, z, z);
		rows.push_back(row);
		row.word = make_word(CMD_SAMPLE, RST_SOFT, z, z, z, z, z, z, z, z);
		rows.push_back(row);
		row.word = make_word(CMD_SAMPLE, RST_SOFT + FRAME_W'(1), z, z, z, z, z, z, z, z);
		rows.push_back(row);
		row.word = make_word(CMD_SAMPLE, RST_CLASS_C, z, z, z, z, z, z, z, z);
		rows.push_back(row);
		row.word = make_word(CMD_SAMPLE, RST_CLASS_C + FRAME_W'(1), z, z, z, z, z, z, z, z);
		rows.push_back(row);
		row.word = make_word(CMD_SAMPLE, RST_HARD, z, z, z, z, z, z, z, z);
		rows.push_back(row);
		row.word = make_word(CMD_SAMPLE, RST_HARD + FRAME_W'(1), z, z, z, z, z, z, z, z);
		rows.push_back(row);
		// one phase over by one, frame well inside budget
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 8; j++)
				p[j] = '0;
			p[i] = phase_cap(i) + PHASE_W'(1);
			row.word = make_word(CMD_SAMPLE, 24'd1000,
				p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
			rows.push_back(row);
		end
		// zero frame drops the minimum back to unset
		row.word = make_word(CMD_SAMPLE, '0, z, z, z, z, z, z, z, z);
		rows.push_back(row);
		row.word = make_word(CMD_CLEAR, 24'd5000, z, z, z, z, z, z, z, z);
		row.typed = 1'b1;
		row.want = fresh_result(0);
		rows.push_back(row);
		// everything at full scale right after a clear
		ext = '0;
		ext.grade = CLASS_E;
		ext.minimum_frame = '1;
		ext.maximum_frame = '1;
		ext.average_frame = '1;
		ext.frame_total = 1;
		ext.budget_violations = 1;
		ext.soft_overruns = 1;
		ext.hard_overruns = 1;
		ext.phase_overruns = 1;
		ext.throttled = 1'b1;
		row.word = make_word(CMD_SAMPLE, '1, '1, '1, '1, '1, '1, '1, '1, '1);
		row.want = ext;
		rows.push_back(row);
		row.typed = 1'b0;
		row.want = '0;
		row.word = make_word(CMD_SAMPLE, 24'd1, z, z, z, z, z, z, z, z);
		rows.push_back(row);
		row.word = make_word(CMD_CLEAR, '1, '1, '1, '1, '1, '1, '1, '1, '1);
		row.typed = 1'b1;
		row.want = fresh_result(0);
		rows.push_back(row);
		row.typed = 1'b0;
		row.want = '0;
		row.word = make_word(CMD_SAMPLE, RST_FRAME_BUDGET - FRAME_W'(1),
			z, z, z, z, z, z, z, z);
		rows.push_back(row);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i])
			send_word(rows[i].word, rows[i].typed, rows[i].want);
		sample_valid <= 1'b0;
		wait_drained();

		// random part, one limit setting per stretch, written only when drained
		for (int s = 0; s < N_SETTINGS; s++) begin
			apply_setting(lim_plan_t'(s % 5));
			for (int i = 0; i < PHASE_WORDS; i++)
				send_word(rand_word(), 1'b0, '0);
			sample_valid <= 1'b0;
			wait_drained();
		end

		repeat (END_SLACK) @(negedge clk);
		if (stats_q.size() != 0)
			note_error($sformatf("%0d results never arrived", stats_q.size()));
		$display("Sent %0d words (%0d clears) under %0d limit settings plus defaults;",
			n_sent, n_clears, N_SETTINGS);
		$display("checked %0d results, %0d over budget, %0d mismatches.",
			n_results, n_over, n_err);
		if (n_err == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
